// File: rtl/tip_pkg.sv
// shared types and constants for the tagged interval profiler
package tip_pkg;

  typedef enum logic [1:0] {
    OP_BEGIN = 2'd0,
    OP_END   = 2'd1,
    OP_CLEAR = 2'd2,
    OP_READ  = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_MISMATCH = 3'd1,
    ST_FULL     = 3'd2,
    ST_UNKNOWN  = 3'd3,
    ST_EMPTY    = 3'd4
  } status_t;

  localparam int TAG_W   = 16;
  localparam int TICK_W  = 63;
  localparam int CALL_W  = 32;
  localparam int SLOT_W  = 4;

  localparam logic [TICK_W-1:0] TICK_MAX = '1;
  localparam logic [CALL_W-1:0] CALL_MAX = '1;

  typedef struct packed {
    logic              begin_hit;
    logic              alloc;
    logic              end_ev;
    logic              clear;
  } slot_cmd_t;

  typedef struct packed {
    logic              valid;
    logic [TAG_W-1:0]  tag;
    logic              open;
    logic [CALL_W-1:0] calls;
    logic [TICK_W-1:0] total;
    logic [TICK_W-1:0] min;
    logic [TICK_W-1:0] max;
  } slot_view_t;

endpackage

// File: rtl/tip_lookup.sv
// parallel tag match and lowest free slot search over the slot table
module tip_lookup #(
  parameter int SLOTS = 16,
  localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
  input  logic [SLOTS-1:0]           valid_vec,
  input  logic [tip_pkg::TAG_W-1:0]  tags [SLOTS],
  input  logic [tip_pkg::TAG_W-1:0]  key,
  output logic [SLOTS-1:0]           hit_oh,
  output logic [SLOTS-1:0]           free_oh,
  output logic [IW-1:0]              hit_idx,
  output logic [IW-1:0]              free_idx
);
  import tip_pkg::*;

  logic [SLOTS-1:0] hit_raw;
  logic [SLOTS-1:0] free_raw;

  always_comb begin
    for (int i = 0; i < SLOTS; i++) begin
      hit_raw[i] = valid_vec[i] && (tags[i] == key);
    end
  end

  assign free_raw = ~valid_vec;

  // keep only the lowest set bit
  assign hit_oh  = hit_raw & (~hit_raw + SLOTS'(1));
  assign free_oh = free_raw & (~free_raw + SLOTS'(1));

  always_comb begin
    hit_idx  = '0;
    free_idx = '0;
    for (int i = 0; i < SLOTS; i++) begin
      if (hit_oh[i]) begin
        hit_idx = IW'(i);
      end
      if (free_oh[i]) begin
        free_idx = IW'(i);
      end
    end
  end

endmodule

// File: rtl/tip_slot.sv
// one slot of the profiler table with its own interval arithmetic
module tip_slot (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        en,
  input  tip_pkg::slot_cmd_t          cmd,
  input  logic [tip_pkg::TAG_W-1:0]   tag,
  input  logic [tip_pkg::TICK_W-1:0]  ts,
  output logic                        valid_q,
  output logic [tip_pkg::TAG_W-1:0]   tag_q,
  output logic                        open_q,
  output tip_pkg::slot_view_t         view_nxt
);
  import tip_pkg::*;

  logic              valid_r, valid_nxt;
  logic [TAG_W-1:0]  tag_r, tag_nxt;
  logic              open_r, open_nxt;
  logic [TICK_W-1:0] start_r, start_nxt;
  logic [CALL_W-1:0] calls_r, calls_nxt;
  logic [TICK_W-1:0] total_r, total_nxt;
  logic [TICK_W-1:0] min_r, min_nxt;
  logic [TICK_W-1:0] max_r, max_nxt;

  logic [TICK_W-1:0] elapsed;
  logic [TICK_W:0]   sum;

  // elapsed time wraps modulo 2^63
  assign elapsed = ts - start_r;
  assign sum     = {1'b0, total_r} + {1'b0, elapsed};

  always_comb begin
    valid_nxt = valid_r;
    tag_nxt   = tag_r;
    open_nxt  = open_r;
    start_nxt = start_r;
    calls_nxt = calls_r;
    total_nxt = total_r;
    min_nxt   = min_r;
    max_nxt   = max_r;
    if (cmd.alloc) begin
      valid_nxt = 1'b1;
      tag_nxt   = tag;
      open_nxt  = 1'b1;
      start_nxt = ts;
      calls_nxt = CALL_W'(1);
      total_nxt = '0;
      min_nxt   = TICK_MAX;
      max_nxt   = '0;
    end else if (cmd.begin_hit) begin
      open_nxt  = 1'b1;
      start_nxt = ts;
      if (calls_r != CALL_MAX) begin
        calls_nxt = calls_r + CALL_W'(1);
      end
    end else if (cmd.end_ev) begin
      open_nxt  = 1'b0;
      total_nxt = sum[TICK_W] ? TICK_MAX : sum[TICK_W-1:0];
      if (elapsed > max_r) begin
        max_nxt = elapsed;
      end
      if (elapsed < min_r) begin
        min_nxt = elapsed;
      end
    end else if (cmd.clear) begin
      // tag and used bit survive a clear
      open_nxt  = 1'b0;
      start_nxt = '0;
      calls_nxt = '0;
      total_nxt = '0;
      min_nxt   = TICK_MAX;
      max_nxt   = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      tag_r   <= '0;
      open_r  <= 1'b0;
      start_r <= '0;
      calls_r <= '0;
      total_r <= '0;
      min_r   <= TICK_MAX;
      max_r   <= '0;
    end else if (en) begin
      valid_r <= valid_nxt;
      tag_r   <= tag_nxt;
      open_r  <= open_nxt;
      start_r <= start_nxt;
      calls_r <= calls_nxt;
      total_r <= total_nxt;
      min_r   <= min_nxt;
      max_r   <= max_nxt;
    end
  end

  assign valid_q = valid_r;
  assign tag_q   = tag_r;
  assign open_q  = open_r;

  assign view_nxt = '{valid: valid_nxt, tag: tag_nxt, open: open_nxt, calls: calls_nxt,
                      total: total_nxt, min: min_nxt, max: max_nxt};

endmodule

// File: rtl/tagged_interval_profiler.sv
// top level of the tagged interval profiler
//
// Requests enter on the in_ channel (valid/ready): begin, end, clear or read,
// with a tag, a timestamp and a slot index for reads. Every request yields
// exactly one result on the out_ channel with a status code and the contents
// of the slot it touched, shown after the update.
// A request is captured in an input register; from there the tag is matched
// against all slots in parallel, the slot arithmetic runs and the result
// register loads once the result register is empty or its result is taken.
// Throughput is one request per cycle while out_ready stays high: the table
// update and the result register load happen together, and the next request
// sees the new state. When out_ready is low the result register holds and
// the input register fills; in_ready drops only once both are occupied.
// Reset empties the table: no slot holds a tag, all statistics are zero and
// the minimum is all ones.
module tagged_interval_profiler #(
  parameter int SLOTS = 16
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [1:0]                  in_operation,
  input  logic [tip_pkg::TAG_W-1:0]   in_tag_id,
  input  logic [tip_pkg::TICK_W-1:0]  in_timestamp,
  input  logic [tip_pkg::SLOT_W-1:0]  in_read_slot,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [2:0]                  out_status,
  output logic [tip_pkg::SLOT_W-1:0]  out_slot,
  output logic                        out_slot_used,
  output logic [tip_pkg::TAG_W-1:0]   out_entry_tag,
  output logic                        out_open_flag,
  output logic [tip_pkg::CALL_W-1:0]  out_call_count,
  output logic [tip_pkg::TICK_W-1:0]  out_total_ticks,
  output logic [tip_pkg::TICK_W-1:0]  out_min_ticks,
  output logic [tip_pkg::TICK_W-1:0]  out_max_ticks
);
  import tip_pkg::*;

  localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  // input register
  logic              s1_valid_r, s1_valid_nxt;
  op_t               s1_op_r;
  logic [TAG_W-1:0]  s1_tag_r;
  logic [TICK_W-1:0] s1_ts_r;
  logic [SLOT_W-1:0] s1_rs_r;

  logic fire;

  // slot table
  logic [SLOTS-1:0] valid_vec;
  logic [SLOTS-1:0] open_vec;
  logic [TAG_W-1:0] tags [SLOTS];
  slot_view_t       views [SLOTS];
  slot_cmd_t        cmds [SLOTS];

  logic [SLOTS-1:0] hit_oh, free_oh;
  logic [IW-1:0]    hit_idx, free_idx;

  logic hit, hit_open, free_any;
  logic [6:0]       rs_w;
  logic             read_oob;
  logic [IW-1:0]    rs_idx;
  logic [SLOTS-1:0] rs_oh;
  logic             rs_valid;

  logic do_begin_hit, do_alloc, do_end, do_clear;
  logic show;
  logic [SLOTS-1:0] sel_oh;
  logic [IW-1:0]    sel_idx;
  logic [SLOT_W-1:0] slot_raw;
  status_t          status;
  slot_view_t       sel_view;

  // result register
  logic              out_valid_r, out_valid_nxt;
  logic [2:0]        status_r;
  logic [SLOT_W-1:0] slot_r, slot_nxt;
  slot_view_t        view_r, view_nxt;

  assign fire     = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || fire;

  assign s1_valid_nxt  = (in_valid && in_ready) || (s1_valid_r && !fire);
  assign out_valid_nxt = fire || (out_valid_r && !out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_op_r  <= op_t'(in_operation);
      s1_tag_r <= in_tag_id;
      s1_ts_r  <= in_timestamp;
      s1_rs_r  <= in_read_slot;
    end
  end

  for (genvar i = 0; i < SLOTS; i++) begin : g_slot
    assign cmds[i] = '{begin_hit: do_begin_hit & hit_oh[i],
                       alloc:     do_alloc & free_oh[i],
                       end_ev:    do_end & hit_oh[i],
                       clear:     do_clear};

    tip_slot u_slot (
      .clk      (clk),
      .rst_n    (rst_n),
      .en       (fire),
      .cmd      (cmds[i]),
      .tag      (s1_tag_r),
      .ts       (s1_ts_r),
      .valid_q  (valid_vec[i]),
      .tag_q    (tags[i]),
      .open_q   (open_vec[i]),
      .view_nxt (views[i])
    );
  end

  tip_lookup #(.SLOTS(SLOTS)) u_lookup (
    .valid_vec (valid_vec),
    .tags      (tags),
    .key       (s1_tag_r),
    .hit_oh    (hit_oh),
    .free_oh   (free_oh),
    .hit_idx   (hit_idx),
    .free_idx  (free_idx)
  );

  assign hit      = |hit_oh;
  assign hit_open = |(hit_oh & open_vec);
  assign free_any = |free_oh;

  assign rs_w     = {3'b000, s1_rs_r};
  assign read_oob = rs_w >= 7'(SLOTS);
  assign rs_idx   = rs_w[IW-1:0];
  assign rs_oh    = SLOTS'(1) << rs_idx;
  assign rs_valid = |(rs_oh & valid_vec);

  always_comb begin
    do_begin_hit = 1'b0;
    do_alloc     = 1'b0;
    do_end       = 1'b0;
    do_clear     = 1'b0;
    show         = 1'b0;
    sel_oh       = '0;
    sel_idx      = '0;
    slot_raw     = '0;
    status       = ST_OK;
    case (s1_op_r)
      OP_BEGIN: begin
        if (hit) begin
          show    = 1'b1;
          sel_oh  = hit_oh;
          sel_idx = hit_idx;
          if (hit_open) begin
            status = ST_MISMATCH;
          end else begin
            do_begin_hit = 1'b1;
          end
        end else if (free_any) begin
          do_alloc = 1'b1;
          show     = 1'b1;
          sel_oh   = free_oh;
          sel_idx  = free_idx;
        end else begin
          status = ST_FULL;
        end
      end
      OP_END: begin
        if (!hit) begin
          status = ST_UNKNOWN;
        end else begin
          show    = 1'b1;
          sel_oh  = hit_oh;
          sel_idx = hit_idx;
          if (!hit_open) begin
            status = ST_MISMATCH;
          end else begin
            do_end = 1'b1;
          end
        end
      end
      OP_CLEAR: begin
        do_clear = 1'b1;
      end
      OP_READ: begin
        if (read_oob) begin
          status   = ST_EMPTY;
          slot_raw = s1_rs_r;
        end else begin
          show    = 1'b1;
          sel_oh  = rs_oh;
          sel_idx = rs_idx;
          status  = rs_valid ? ST_OK : ST_EMPTY;
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    sel_view = '0;
    for (int i = 0; i < SLOTS; i++) begin
      if (sel_oh[i]) begin
        sel_view = views[i];
      end
    end
  end

  assign view_nxt = show ? sel_view : '0;
  assign slot_nxt = show ? SLOT_W'(sel_idx) : slot_raw;

  always_ff @(posedge clk) begin
    if (fire) begin
      status_r <= status;
      slot_r   <= slot_nxt;
      view_r   <= view_nxt;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_status      = status_r;
  assign out_slot        = slot_r;
  assign out_slot_used   = view_r.valid;
  assign out_entry_tag   = view_r.tag;
  assign out_open_flag   = view_r.open;
  assign out_call_count  = view_r.calls;
  assign out_total_ticks = view_r.total;
  assign out_min_ticks   = view_r.min;
  assign out_max_ticks   = view_r.max;

endmodule

// File: rtl/tip_checker.sv
// port-level checks for the tagged interval profiler, bound to the top level
module tip_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [2:0]                  out_status,
  input logic [tip_pkg::SLOT_W-1:0]  out_slot,
  input logic                        out_slot_used,
  input logic [tip_pkg::TAG_W-1:0]   out_entry_tag,
  input logic                        out_open_flag,
  input logic [tip_pkg::CALL_W-1:0]  out_call_count,
  input logic [tip_pkg::TICK_W-1:0]  out_total_ticks,
  input logic [tip_pkg::TICK_W-1:0]  out_min_ticks,
  input logic [tip_pkg::TICK_W-1:0]  out_max_ticks
);
  import tip_pkg::*;

  // a stalled result stays put
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_status) && $stable(out_slot)
      && $stable(out_total_ticks) && $stable(out_call_count))
    else $error("result changed while stalled");

  a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_status <= ST_EMPTY)
    else $error("status code out of range");

  // table full and unknown tag carry no slot contents
  a_no_slot: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == ST_FULL || out_status == ST_UNKNOWN) |->
      out_slot == '0 && !out_slot_used && !out_open_flag && out_call_count == '0
      && out_min_ticks == '0)
    else $error("failed lookup shows slot contents");

  // an ok result without a used slot only comes from a clear
  a_clear_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == ST_OK && !out_slot_used |->
      out_slot == '0 && !out_open_flag && out_call_count == '0
      && out_total_ticks == '0 && out_max_ticks == '0 && out_entry_tag == '0)
    else $error("ok result on an unused slot carries data");

endmodule

bind tagged_interval_profiler tip_checker u_tip_checker (.*);

// File: tb/testbench.sv
// self-checking testbench for the tagged interval profiler
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import tip_pkg::*;

  localparam int SLOTS       = 16;
  localparam int CYCLE_LIMIT = 500000;

  typedef struct packed {
    status_t            status;
    logic [SLOT_W-1:0]  slot;
    logic               used;
    logic [TAG_W-1:0]   tag;
    logic               open;
    logic [CALL_W-1:0]  calls;
    logic [TICK_W-1:0]  total;
    logic [TICK_W-1:0]  shortest;
    logic [TICK_W-1:0]  longest;
  } profile_result_t;

  logic                clk;
  logic                rst_n;
  logic                in_valid;
  logic                in_ready;
  logic [1:0]          in_operation;
  logic [TAG_W-1:0]    in_tag_id;
  logic [TICK_W-1:0]   in_timestamp;
  logic [SLOT_W-1:0]   in_read_slot;
  logic                out_valid;
  logic                out_ready;
  logic [2:0]          out_status;
  logic [SLOT_W-1:0]   out_slot;
  logic                out_slot_used;
  logic [TAG_W-1:0]    out_entry_tag;
  logic                out_open_flag;
  logic [CALL_W-1:0]   out_call_count;
  logic [TICK_W-1:0]   out_total_ticks;
  logic [TICK_W-1:0]   out_min_ticks;
  logic [TICK_W-1:0]   out_max_ticks;

  // predicted contents of the slot table
  logic                tab_used     [SLOTS];
  logic                tab_open     [SLOTS];
  logic [TAG_W-1:0]    tab_tag      [SLOTS];
  logic [TICK_W-1:0]   tab_start    [SLOTS];
  logic [CALL_W-1:0]   tab_calls    [SLOTS];
  logic [TICK_W-1:0]   tab_total    [SLOTS];
  logic [TICK_W-1:0]   tab_shortest [SLOTS];
  logic [TICK_W-1:0]   tab_longest  [SLOTS];

  profile_result_t     pending_results[$];
  logic [TAG_W-1:0]    tag_pool[16];
  logic [TICK_W-1:0]   stamp_clock;
  bit                  idle_enable;
  int                  mismatch_count;
  int                  cycle_count;

  tagged_interval_profiler dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_operation    (in_operation),
    .in_tag_id       (in_tag_id),
    .in_timestamp    (in_timestamp),
    .in_read_slot    (in_read_slot),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_status      (out_status),
    .out_slot        (out_slot),
    .out_slot_used   (out_slot_used),
    .out_entry_tag   (out_entry_tag),
    .out_open_flag   (out_open_flag),
    .out_call_count  (out_call_count),
    .out_total_ticks (out_total_ticks),
    .out_min_ticks   (out_min_ticks),
    .out_max_ticks   (out_max_ticks)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  function automatic void wipe_slot(int idx);
    tab_open[idx]     = 1'b0;
    tab_start[idx]    = '0;
    tab_calls[idx]    = '0;
    tab_total[idx]    = '0;
    tab_longest[idx]  = '0;
    tab_shortest[idx] = TICK_MAX;
  endfunction

  function automatic int lookup_slot(logic [TAG_W-1:0] tag);
    for (int i = 0; i < SLOTS; i++)
      if (tab_used[i] && tab_tag[i] == tag) return i;
    return -1;
  endfunction

  function automatic int free_slot();
    for (int i = 0; i < SLOTS; i++)
      if (!tab_used[i]) return i;
    return -1;
  endfunction

  function automatic profile_result_t slot_view(status_t st, int idx);
    profile_result_t res;
    res.status   = st;
    res.slot     = SLOT_W'(idx);
    res.used     = tab_used[idx];
    res.tag      = tab_tag[idx];
    res.open     = tab_open[idx];
    res.calls    = tab_calls[idx];
    res.total    = tab_total[idx];
    res.shortest = tab_shortest[idx];
    res.longest  = tab_longest[idx];
    return res;
  endfunction

  // updates the predicted table for one request and queues the result it yields
  function automatic void profile_request(op_t op, logic [TAG_W-1:0] tag,
                                          logic [TICK_W-1:0] ts, logic [SLOT_W-1:0] rs);
    profile_result_t   res;
    int                idx;
    logic [TICK_W-1:0] elapsed;
    res = '0;
    idx = lookup_slot(tag);
    case (op)
      OP_BEGIN: begin
        if (idx >= 0 && tab_open[idx]) begin
          res = slot_view(ST_MISMATCH, idx);
        end else begin
          if (idx >= 0) begin
            if (tab_calls[idx] != CALL_MAX) tab_calls[idx] = tab_calls[idx] + 1'b1;
          end else begin
            idx = free_slot();
            if (idx >= 0) begin
              wipe_slot(idx);
              tab_used[idx]  = 1'b1;
              tab_tag[idx]   = tag;
              tab_calls[idx] = 1;
            end
          end
          if (idx < 0) begin
            res.status = ST_FULL;
          end else begin
            tab_start[idx] = ts;
            tab_open[idx]  = 1'b1;
            res = slot_view(ST_OK, idx);
          end
        end
      end
      OP_END: begin
        if (idx < 0) begin
          res.status = ST_UNKNOWN;
        end else if (!tab_open[idx]) begin
          res = slot_view(ST_MISMATCH, idx);
        end else begin
          // modulo 2^63 difference covers a wrapped tick counter
          elapsed = ts - tab_start[idx];
          if (elapsed > TICK_MAX - tab_total[idx]) tab_total[idx] = TICK_MAX;
          else tab_total[idx] = tab_total[idx] + elapsed;
          if (elapsed > tab_longest[idx]) tab_longest[idx] = elapsed;
          if (elapsed < tab_shortest[idx]) tab_shortest[idx] = elapsed;
          tab_open[idx] = 1'b0;
          res = slot_view(ST_OK, idx);
        end
      end
      OP_CLEAR: begin
        for (int i = 0; i < SLOTS; i++)
          if (tab_used[i]) wipe_slot(i);
      end
      default: begin
        res = slot_view(tab_used[rs] ? ST_OK : ST_EMPTY, rs);
      end
    endcase
    pending_results.push_back(res);
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (!idle_enable || r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic logic [TICK_W-1:0] next_stamp();
    int r;
    r = $urandom_range(0, 99);
    if (r < 85) stamp_clock = stamp_clock + TICK_W'($urandom_range(0, 2000));
    else if (r < 95) stamp_clock = stamp_clock + TICK_W'({$urandom, $urandom});
    else stamp_clock = TICK_MAX - TICK_W'($urandom_range(0, 3000));
    return stamp_clock;
  endfunction

  task automatic send_request(op_t op, logic [TAG_W-1:0] tag, logic [TICK_W-1:0] ts,
                              logic [SLOT_W-1:0] rs);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_operation <= op;
    in_tag_id    <= tag;
    in_timestamp <= ts;
    in_read_slot <= rs;
    do @(posedge clk); while (!in_ready);
    profile_request(op, tag, ts, rs);
  endtask

  task automatic wait_for_results();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic test_empty_table();
    send_request(OP_READ, 16'h0000, '0, 4'd0);
    send_request(OP_READ, 16'hFFFF, TICK_MAX, 4'd15);
    send_request(OP_END, 16'h1234, 63'd10, 4'd0);
  endtask

  task automatic test_interval_extremes();
    send_request(OP_BEGIN, 16'h0000, '0, 4'd15);
    send_request(OP_BEGIN, 16'h0000, 63'd7, 4'd0);      // begin while open
    send_request(OP_END, 16'h0000, TICK_MAX, 4'd0);     // longest possible interval
    send_request(OP_END, 16'h0000, 63'd9, 4'd15);       // end while closed
    send_request(OP_BEGIN, 16'h0000, TICK_MAX, 4'd0);
    send_request(OP_END, 16'h0000, 63'd3, 4'd0);        // wrap, total saturates
    send_request(OP_BEGIN, 16'h0000, 63'd50, 4'd0);
    send_request(OP_END, 16'h0000, 63'd50, 4'd0);       // zero-length interval
    send_request(OP_BEGIN, 16'hFFFF, 63'd100, 4'd0);
    send_request(OP_READ, 16'h0000, '0, 4'd1);
  endtask

  task automatic test_clear_keeps_tags();
    send_request(OP_CLEAR, 16'hFFFF, TICK_MAX, 4'd15);
    send_request(OP_READ, 16'h0000, '0, 4'd0);
    send_request(OP_END, 16'hFFFF, 63'd200, 4'd0);
    send_request(OP_BEGIN, 16'hFFFF, 63'd300, 4'd0);
    send_request(OP_READ, 16'h0000, '0, 4'd15);
  endtask

  // mostly paired begin/end on a fixed set of tags; stray tags only once the
  // table is full, since a slot is never freed after reset
  task automatic test_random_traffic(int count);
    int               r;
    int               idx;
    bit               is_open;
    logic [TAG_W-1:0] tag;
    for (int n = 0; n < count; n++) begin
      r = $urandom_range(0, 99);
      if (r < 80 && (r < 72 || free_slot() >= 0)) begin
        tag = tag_pool[$urandom_range(0, 15)];
        idx = lookup_slot(tag);
        is_open = idx >= 0 && tab_open[idx];
        if ($urandom_range(0, 9) == 0) is_open = !is_open;
        send_request(is_open ? OP_END : OP_BEGIN, tag, next_stamp(), SLOT_W'($urandom));
      end else if (r < 80) begin
        send_request($urandom_range(0, 1) ? OP_END : OP_BEGIN, TAG_W'($urandom),
                     next_stamp(), SLOT_W'($urandom));
      end else if (r < 83) begin
        send_request(OP_CLEAR, TAG_W'($urandom), next_stamp(), SLOT_W'($urandom));
      end else begin
        send_request(OP_READ, TAG_W'($urandom), next_stamp(), SLOT_W'($urandom));
      end
    end
  endtask

  // result stalls: mostly short, now and then long
  initial begin
    int len;
    out_ready <= 1'b1;
    @(posedge clk iff rst_n);
    forever begin
      out_ready <= 1'b1;
      len = $urandom_range(1, 12);
      repeat (len) @(posedge clk);
      if (idle_enable) begin
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 30) : $urandom_range(0, 3);
        if (len > 0) begin
          out_ready <= 1'b0;
          repeat (len) @(posedge clk);
        end
      end
    end
  end

  always @(posedge clk) begin : result_check
    profile_result_t seen;
    profile_result_t want;
    if (rst_n && out_valid && out_ready) begin
      seen.status   = status_t'(out_status);
      seen.slot     = out_slot;
      seen.used     = out_slot_used;
      seen.tag      = out_entry_tag;
      seen.open     = out_open_flag;
      seen.calls    = out_call_count;
      seen.total    = out_total_ticks;
      seen.shortest = out_min_ticks;
      seen.longest  = out_max_ticks;
      if (pending_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("%0t: unexpected result status=%0d slot=%0d", $realtime,
                   out_status, out_slot);
      end else begin
        want = pending_results.pop_front();
        if (seen !== want) begin
          mismatch_count++;
          if (mismatch_count <= 10) begin
            $display("%0t: result mismatch", $realtime);
            $display("  expected st=%0d slot=%0d used=%b tag=%h open=%b calls=%0d",
                     want.status, want.slot, want.used, want.tag, want.open, want.calls);
            $display("           total=%h min=%h max=%h",
                     want.total, want.shortest, want.longest);
            $display("  actual   st=%0d slot=%0d used=%b tag=%h open=%b calls=%0d",
                     seen.status, seen.slot, seen.used, seen.tag, seen.open, seen.calls);
            $display("           total=%h min=%h max=%h",
                     seen.total, seen.shortest, seen.longest);
          end
        end
      end
    end
  end

  initial begin
    bit dup;
    cycle_count    = 0;
    mismatch_count = 0;
    idle_enable    = 1'b1;
    stamp_clock    = '0;
    rst_n        <= 1'b0;
    in_valid     <= 1'b0;
    in_operation <= OP_BEGIN;
    in_tag_id    <= '0;
    in_timestamp <= '0;
    in_read_slot <= '0;
    for (int i = 0; i < SLOTS; i++) begin
      tab_used[i] = 1'b0;
      tab_tag[i]  = '0;
      wipe_slot(i);
    end
    // two extreme tags plus fourteen distinct random ones fill the table
    tag_pool[0] = 16'h0000;
    tag_pool[1] = 16'hFFFF;
    for (int i = 2; i < 16; i++) begin
      do begin
        tag_pool[i] = TAG_W'($urandom);
        dup = 1'b0;
        for (int j = 0; j < i; j++)
          if (tag_pool[j] == tag_pool[i]) dup = 1'b1;
      end while (dup);
    end
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_empty_table();
    test_interval_extremes();
    test_clear_keeps_tags();
    test_random_traffic(600);
    wait_for_results();
    idle_enable = 1'b0;
    test_random_traffic(250);
    idle_enable = 1'b1;
    test_random_traffic(800);

    wait_for_results();
    repeat (10) @(posedge clk);
    if (mismatch_count == 0) $display("[ OK ] regression clean");
    else $display("[FAIL] regression broken");
    $finish;
  end

endmodule
